[rtl/core/h2cr_pkg.sv]
// Shared types and constants for the Hermitian 2x2 complex rotation pipeline.
// No dependencies.
package h2cr_pkg;

  // Default matrix/rotation word width (Q16.16 data, Q2.30 cosine/sine)
  localparam int H2CR_DATA_W = 32;

  // Multipliers in each product bank
  localparam int H2CR_NMUL = 12;

  // Load enables for the two register stages of a product bank
  typedef struct packed {
    logic mul;  // raw product register
    logic rnd;  // rounded product register
  } h2cr_bank_en_t;

endpackage

[rtl/core/h2cr_mulbank.sv]
// Bank of twelve signed multipliers: product register, then rounding register.
// Depends on h2cr_pkg.
module h2cr_mulbank import h2cr_pkg::*; #(
  parameter int DATA_WIDTH = H2CR_DATA_W
) (
  input  logic                          clk,
  input  h2cr_bank_en_t                 en_i,
  input  logic signed [DATA_WIDTH-1:0]  a_i [H2CR_NMUL],
  input  logic signed [DATA_WIDTH-1:0]  b_i [H2CR_NMUL],
  output logic signed [DATA_WIDTH+1:0]  r_o [H2CR_NMUL]
);

  localparam int PW   = 2 * DATA_WIDTH;
  localparam int SH   = DATA_WIDTH - 2;
  localparam logic signed [PW-1:0] BIAS = PW'(1) <<< (SH - 1);

  logic signed [PW-1:0]         prod_r [H2CR_NMUL];
  logic signed [DATA_WIDTH+1:0] rnd_r  [H2CR_NMUL];

  for (genvar i = 0; i < H2CR_NMUL; i++) begin : g_mul
    logic signed [PW-1:0] biased;

    // exact product
    always_ff @(posedge clk) begin
      if (en_i.mul) begin
        prod_r[i] <= PW'(a_i[i]) * PW'(b_i[i]);
      end
    end

    // round to nearest, ties up: floor((p + half) / 2^SH)
    assign biased = prod_r[i] + BIAS;

    always_ff @(posedge clk) begin
      if (en_i.rnd) begin
        rnd_r[i] <= biased[PW-1:SH];
      end
    end

    assign r_o[i] = rnd_r[i];
  end

endmodule

[rtl/core/hermitian_2x2_complex_rotation.sv]
// Stages: bank 1 product and rounding, t1/t2, t3-t6, bank 2 product and rounding, output.
// Throughput: one beat per cycle while out_tready is high; each of the seven stages holds
// one item and moves on as soon as the stage after it has room, so bubbles are squeezed out.
// Reset (synchronous, rst_n low) clears only the stage valid bits; data
// registers keep whatever they hold.
// Depends on h2cr_pkg and h2cr_mulbank.
module hermitian_2x2_complex_rotation import h2cr_pkg::*; #(
  parameter int DATA_WIDTH = H2CR_DATA_W,
  localparam int IN_TW  = ((7 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // x_diag, y_diag, z_re, z_im, cos_val, sin_re, sin_im
  input  logic              in_tlast,   // last_in
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,  // x_new, y_new, z_new_re, z_new_im
  output logic              out_tlast   // last_out
);

  localparam int DW    = DATA_WIDTH;
  localparam int RW    = DW + 2;   // rounded product
  localparam int SW    = DW + 4;   // sum of up to three rounded products
  localparam int NSTG  = 7;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[DW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[DW-1:0];
    end else begin
      res = v[DW-1:0];
    end
    return res;
  endfunction

  // input fields
  logic signed [DW-1:0] x_in, y_in, zr_in, zi_in, c_in, sr_in, si_in;
  assign x_in  = in_tdata[0*DW +: DW];
  assign y_in  = in_tdata[1*DW +: DW];
  assign zr_in = in_tdata[2*DW +: DW];
  assign zi_in = in_tdata[3*DW +: DW];
  assign c_in  = in_tdata[4*DW +: DW];
  assign sr_in = in_tdata[5*DW +: DW];
  assign si_in = in_tdata[6*DW +: DW];

  // stage valid bits and load enables
  logic [NSTG-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = ({v_r[NSTG-2:0], in_tvalid} & en) | (v_r & ~en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = en[0];

  // rotation coefficients and last flag travel alongside the data
  logic signed [DW-1:0] c_r  [4];
  logic signed [DW-1:0] sr_r [4];
  logic signed [DW-1:0] si_r [4];
  logic [NSTG-1:0]      last_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_r[0]    <= c_in;
      sr_r[0]   <= sr_in;
      si_r[0]   <= si_in;
      last_r[0] <= in_tlast;
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        c_r[k]  <= c_r[k-1];
        sr_r[k] <= sr_r[k-1];
        si_r[k] <= si_r[k-1];
      end
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // stages 0-1: first product bank
  logic signed [DW-1:0] a1 [H2CR_NMUL];
  logic signed [DW-1:0] b1 [H2CR_NMUL];
  logic signed [RW-1:0] p1 [H2CR_NMUL];
  h2cr_bank_en_t        bank1_en;

  assign a1 = '{sr_in, si_in, sr_in, si_in, c_in, c_in,
                sr_in, si_in, sr_in, si_in, c_in, c_in};
  assign b1 = '{zr_in, zi_in, zi_in, zr_in, zr_in, zi_in,
                x_in,  x_in,  y_in,  y_in,  x_in, y_in};
  assign bank1_en = '{mul: en[0], rnd: en[1]};

  h2cr_mulbank #(.DATA_WIDTH(DATA_WIDTH)) u_bank1 (
    .clk  (clk),
    .en_i (bank1_en),
    .a_i  (a1),
    .b_i  (b1),
    .r_o  (p1)
  );

  // stage 2: t1, t2 and hold the diagonal products
  logic signed [DW-1:0] t1r_r, t1i_r, t2r_r, t2i_r;
  logic signed [RW-1:0] srx_r, six_r, sry_r, siy_r, cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t1r_r <= sat(SW'(p1[0]) - SW'(p1[1]));
      t1i_r <= sat(SW'(p1[2]) + SW'(p1[3]));
      t2r_r <= sat(SW'(p1[4]));
      t2i_r <= sat(SW'(p1[5]));
      srx_r <= p1[6];
      six_r <= p1[7];
      sry_r <= p1[8];
      siy_r <= p1[9];
      cx_r  <= p1[10];
      cy_r  <= p1[11];
    end
  end

  // stage 3: t3, t4, t5, t6
  logic signed [DW-1:0] t3r_r, t3i_r, t4r_r, t4i_r, t5_r, t6_r, t1i_s3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3r_r    <= sat(SW'(t2r_r) - SW'(srx_r));
      t3i_r    <= sat(SW'(t2i_r) + SW'(six_r));
      t4r_r    <= sat(SW'(t2r_r) + SW'(sry_r));
      t4i_r    <= sat(SW'(siy_r) - SW'(t2i_r));
      t5_r     <= sat(SW'(cx_r) + SW'(t1r_r));
      t6_r     <= sat(SW'(cy_r) - SW'(t1r_r));
      t1i_s3_r <= t1i_r;
    end
  end

  // stages 4-5: second product bank
  logic signed [DW-1:0] a2 [H2CR_NMUL];
  logic signed [DW-1:0] b2 [H2CR_NMUL];
  logic signed [RW-1:0] p2 [H2CR_NMUL];
  h2cr_bank_en_t        bank2_en;

  assign a2 = '{c_r[3], sr_r[3], si_r[3], c_r[3], sr_r[3], si_r[3],
                c_r[3], sr_r[3], si_r[3], c_r[3], sr_r[3], si_r[3]};
  assign b2 = '{t5_r,  t4r_r, t4i_r,    t6_r,  t3r_r,    t3i_r,
                t3r_r, t6_r,  t1i_s3_r, t3i_r, t1i_s3_r, t6_r};
  assign bank2_en = '{mul: en[4], rnd: en[5]};

  h2cr_mulbank #(.DATA_WIDTH(DATA_WIDTH)) u_bank2 (
    .clk  (clk),
    .en_i (bank2_en),
    .a_i  (a2),
    .b_i  (b2),
    .r_o  (p2)
  );

  // stage 6: final sums, output register
  logic signed [DW-1:0] xn_r, yn_r, znr_r, zni_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      xn_r  <= sat(SW'(p2[0]) + SW'(p2[1])  + SW'(p2[2]));
      yn_r  <= sat(SW'(p2[3]) - SW'(p2[4])  + SW'(p2[5]));
      znr_r <= sat(SW'(p2[6]) + SW'(p2[7])  + SW'(p2[8]));
      zni_r <= sat(SW'(p2[9]) + SW'(p2[10]) - SW'(p2[11]));
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tlast  = last_r[NSTG-1];
  assign out_tdata  = OUT_TW'({zni_r, znr_r, yn_r, xn_r});

  // input stalls only when every stage is occupied and the sink holds off
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v_r == {NSTG{1'b1}}) && !out_tready)
    else $error("input stalled with a free pipeline stage");

  // an item in the last bank stage reaches the output when it moves
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en[NSTG-1] && v_r[NSTG-2] |=> out_tvalid)
    else $error("item lost between bank and output register");

  // no result appears out of a bubble
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    en[NSTG-1] && !v_r[NSTG-2] |=> !out_tvalid)
    else $error("result produced from an empty stage");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("valid bits not cleared by reset");

endmodule

[tb/tb_hermitian_2x2_complex_rotation.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hermitian_2x2_complex_rotation: a bit-exact fixed-point
// predictor in a scoreboard class checks every result beat in order.
// Depends on h2cr_pkg and the rotation pipeline RTL.
module tb_hermitian_2x2_complex_rotation;
  import h2cr_pkg::*;

  localparam int DW = H2CR_DATA_W;
  localparam int CS_FRAC = DW - 2;
  localparam int IN_TW = ((7 * DW + 7) / 8) * 8;
  localparam int OUT_TW = ((4 * DW + 7) / 8) * 8;
  localparam int PIPE_LAT = 7;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 217;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t W_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam word_t W_ONE_CS = word_t'(longint'(1) <<< CS_FRAC);  // 1.0 in Q2.30
  localparam word_t W_HALF_CS = word_t'(longint'(1) <<< (CS_FRAC - 1));
  localparam word_t W_ONE_Q = word_t'(longint'(1) <<< 16);        // 1.0 in Q16.16

  typedef struct packed {
    logic  last;
    word_t sin_im;
    word_t sin_re;
    word_t cos_val;
    word_t z_im;
    word_t z_re;
    word_t y_diag;
    word_t x_diag;
  } matrix_t;

  typedef struct packed {
    logic  last;
    word_t z_new_im;
    word_t z_new_re;
    word_t y_new;
    word_t x_new;
  } rotated_t;

  // Scoreboard: predicts the rotated matrix for each accepted input beat
  class rotation_scoreboard;
    rotated_t pending_rot[$];
    int matrices_in;
    int lasts_in;
    int results_checked;
    int errors;

    localparam longint SAT_HI = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    function longint clamp(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // exact product, round to nearest with ties toward +inf
    function longint rprod(longint a, longint b);
      return (a * b + (longint'(1) <<< (CS_FRAC - 1))) >>> CS_FRAC;
    endfunction

    function rotated_t rotate_matrix(matrix_t m);
      longint x, y, zr, zi, ci, sr, si;
      longint t1r, t1i, t2r, t2i, t3r, t3i, t4r, t4i, t5, t6;
      rotated_t r;
      x = m.x_diag;
      y = m.y_diag;
      zr = m.z_re;
      zi = m.z_im;
      ci = m.cos_val;
      sr = m.sin_re;
      si = m.sin_im;
      t1r = clamp(rprod(sr, zr) - rprod(si, zi));
      t1i = clamp(rprod(sr, zi) + rprod(si, zr));
      t2r = clamp(rprod(ci, zr));
      t2i = clamp(rprod(ci, zi));
      t3r = clamp(t2r - rprod(sr, x));
      t3i = clamp(t2i + rprod(si, x));
      t4r = clamp(t2r + rprod(sr, y));
      t4i = clamp(-t2i + rprod(si, y));
      t5 = clamp(rprod(ci, x) + t1r);
      t6 = clamp(rprod(ci, y) - t1r);
      r.x_new = word_t'(clamp(rprod(ci, t5) + rprod(sr, t4r) + rprod(si, t4i)));
      r.y_new = word_t'(clamp(rprod(ci, t6) - rprod(sr, t3r) + rprod(si, t3i)));
      r.z_new_re = word_t'(clamp(rprod(ci, t3r) + rprod(sr, t6) + rprod(si, t1i)));
      r.z_new_im = word_t'(clamp(rprod(ci, t3i) + rprod(sr, t1i) - rprod(si, t6)));
      r.last = m.last;
      return r;
    endfunction

    function void note_matrix(matrix_t m);
      pending_rot.push_back(rotate_matrix(m));
      matrices_in++;
      if (m.last) lasts_in++;
    endfunction

    function void cmp_field(string fname, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", fname, want, got);
        errors++;
      end
    endfunction

    function void check_rotated(rotated_t got);
      rotated_t want;
      if (pending_rot.size() == 0) begin
        $error("result beat with no matrix outstanding: x_new %0d", got.x_new);
        errors++;
        return;
      end
      want = pending_rot.pop_front();
      results_checked++;
      cmp_field("x_new", want.x_new, got.x_new);
      cmp_field("y_new", want.y_new, got.y_new);
      cmp_field("z_new_re", want.z_new_re, got.z_new_re);
      cmp_field("z_new_im", want.z_new_im, got.z_new_im);
      cmp_field("last_out", want.last, got.last);
    endfunction

    function int outstanding();
      return pending_rot.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic out_tlast;

  rotation_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked = 0;
  int holds_done = 0;
  int idle_cycles = 0;
  int directed_sent = 0;

  hermitian_2x2_complex_rotation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // Drive one matrix beat; random idle gap first, hold until accepted
  task automatic send_matrix(input matrix_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {m.sin_im, m.sin_re, m.cos_val, m.z_im, m.z_re, m.y_diag, m.x_diag};
    in_tlast = m.last;
    do @(posedge clk); while (!in_tready);
    sb.note_matrix(m);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic matrix_t mk(word_t x, word_t y, word_t zr, word_t zi,
                                 word_t c, word_t sr, word_t si, logic last);
    matrix_t m;
    m = '{last: last, sin_im: si, sin_re: sr, cos_val: c, z_im: zi, z_re: zr,
          y_diag: y, x_diag: x};
    return m;
  endfunction

  function automatic word_t rand_span(longint span);
    return word_t'(longint'($urandom_range(32'(2 * span))) - span);
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(5))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return '1;
      4: return word_t'(1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Mostly plausible rotations of moderate matrices, some corner mixes and raw noise
  function automatic matrix_t gen_matrix();
    int kind;
    matrix_t m;
    kind = $urandom_range(99);
    if (kind < 15) begin
      m = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
    end else if (kind < 25) begin
      m = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
             pick_extreme(), pick_extreme(), pick_extreme(), 1'b0);
    end else begin
      m = mk(rand_span(1 << 21), rand_span(1 << 21), rand_span(1 << 21), rand_span(1 << 21),
             rand_span(longint'(1) << 30), rand_span(1 << 29), rand_span(1 << 29), 1'b0);
    end
    m.last = ($urandom_range(7) == 0);
    return m;
  endfunction

  task automatic run_random(input int count, input bit with_holds);
    for (int i = 0; i < count; i++) begin
      if (with_holds && (i == 0 || i == count / 2)) holds_asked++;
      send_matrix(gen_matrix());
    end
  endtask

  task automatic run_directed();
    matrix_t dir_q[$];
    dir_q.push_back(mk('0, '0, '0, '0, '0, '0, '0, 1'b0));
    // identity rotation leaves the matrix alone
    dir_q.push_back(mk(W_ONE_Q, 2 * W_ONE_Q, W_ONE_Q / 2, -W_ONE_Q / 4,
                       W_ONE_CS, '0, '0, 1'b0));
    // pure real sine swaps diagonals
    dir_q.push_back(mk(3 * W_ONE_Q, -W_ONE_Q, W_ONE_Q, W_ONE_Q, '0, W_ONE_CS, '0, 1'b0));
    // pure imaginary sine
    dir_q.push_back(mk(3 * W_ONE_Q, -W_ONE_Q, W_ONE_Q, -W_ONE_Q, '0, '0, W_ONE_CS, 1'b1));
    // 45 degree rotation with complex off-diagonal
    dir_q.push_back(mk(5 * W_ONE_Q, W_ONE_Q, 2 * W_ONE_Q, 7 * W_ONE_Q,
                       word_t'(759250125), word_t'(536870912), word_t'(-536870912), 1'b0));
    // all fields at the top, then the bottom of their range: saturation everywhere
    dir_q.push_back(mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1));
    dir_q.push_back(mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1));
    dir_q.push_back(mk(W_MAX, W_MIN, W_MAX, W_MIN, W_MIN, W_MAX, W_MIN, 1'b0));
    dir_q.push_back(mk(W_MIN, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, 1'b0));
    // cosine of -2.0, far from unitary
    dir_q.push_back(mk(W_MAX / 3, W_MIN / 5, W_MAX / 7, W_MAX / 2, W_MIN, W_ONE_CS,
                       W_ONE_CS, 1'b0));
    dir_q.push_back(mk('1, '1, '1, '1, '1, '1, '1, 1'b1));
    // rounding ties, both signs
    dir_q.push_back(mk(word_t'(1), word_t'(-1), word_t'(1), word_t'(-1),
                       W_HALF_CS, W_HALF_CS, -W_HALF_CS, 1'b0));
    dir_q.push_back(mk(word_t'(3), word_t'(-3), word_t'(-1), word_t'(1),
                       W_HALF_CS, -W_HALF_CS, W_HALF_CS, 1'b0));
    // alternating bit patterns
    dir_q.push_back(mk(word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa),
                       word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa),
                       word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555),
                       word_t'(32'haaaa_aaaa), 1'b0));
    dir_q.push_back(mk(word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555),
                       word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555),
                       word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa),
                       word_t'(32'h5555_5555), 1'b1));
    // zero rotation wipes everything
    dir_q.push_back(mk(W_MAX, W_MIN, W_MAX, W_MIN, '0, '0, '0, 1'b0));
    // large off-diagonal with sine near 2.0 + 2.0i saturates the imaginary t1 term
    dir_q.push_back(mk('0, '0, W_MAX, W_MAX, '0, W_MAX, W_MAX, 1'b1));
    foreach (dir_q[i]) send_matrix(dir_q[i]);
    directed_sent = dir_q.size();
  endtask

  // Receiver: random backpressure plus long hold-offs on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_rotated('{last: out_tlast, z_new_im: out_tdata[4*DW-1:3*DW],
                           z_new_re: out_tdata[3*DW-1:2*DW], y_new: out_tdata[2*DW-1:DW],
                           x_new: out_tdata[DW-1:0]});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 73;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(RAND_PER_PHASE, 1'b0);

    send_idle_pct = 73;
    recv_idle_pct = 23;
    run_random(RAND_PER_PHASE, 1'b0);
    wait_drained();

    // full rate, with receiver hold-offs to back up the pipeline
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RAND_PER_PHASE, 1'b1);
    wait_drained();
    repeat (3 * PIPE_LAT) @(negedge clk);

    $display("Sent %0d matrices (%0d directed, %0d marked last), %0d results checked",
             sb.matrices_in, directed_sent, sb.lasts_in, sb.results_checked);
    $display("Idle mixes 23/73, 73/23 and none; %0d receiver hold-offs of %0d cycles",
             holds_done, HOLD_CYCLES);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
